[rtl/core/swq_pkg.sv]
// Shared types, constants and codes of the semaphore wait queue.
`default_nettype none

package swq_pkg;

  localparam int unsigned SLOTS  = 8;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // request kinds
  localparam logic REQ_WAIT   = 1'b0;
  localparam logic REQ_SIGNAL = 1'b1;

  // result status codes
  localparam logic [1:0] ST_PROCEED   = 2'd0;
  localparam logic [1:0] ST_BLOCKED   = 2'd1;
  localparam logic [1:0] ST_ADDR_TRAP = 2'd2;
  localparam logic [1:0] ST_NO_SLOT   = 2'd3;

  // configuration register indexes
  localparam logic CFG_SHARE_BASE  = 1'b0;
  localparam logic CFG_SHARE_BYTES = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [31:0]        sem_addr;
    logic signed [31:0] sem_count;
    logic [7:0]         requester;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] new_count;
    logic               wake_valid;
    logic [7:0]         wake_id;
  } resp_t;

  typedef struct packed {
    logic              busy;
    logic [31:0]       addr;
    logic [7:0]        owner;
    logic [SLOT_W-1:0] rank;
  } slot_rd_t;

  typedef struct packed {
    logic              alloc;
    logic [31:0]       alloc_addr;
    logic [7:0]        alloc_owner;
    logic [SLOT_W-1:0] alloc_rank;
    logic              release_en;
    logic [SLOT_W-1:0] release_idx;
    logic              rank_dec;
    logic [SLOT_W-1:0] rank_idx;
  } slot_cmd_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } slot_free_t;

endpackage

`default_nettype wire

[rtl/core/swq_slot_table.sv]
// Wait list slot storage: busy flags, addresses, owners and arrival ranks.
`default_nettype none

module swq_slot_table import swq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slot_cmd_t         cmd_i,
  input  logic [SLOT_W-1:0] rd_idx_i,
  output slot_rd_t          rd_o,
  output slot_free_t        free_o
);

  logic [SLOTS-1:0]  busy_q, busy_d;
  logic [31:0]       addr_q  [SLOTS];
  logic [7:0]        owner_q [SLOTS];
  logic [SLOT_W-1:0] rank_q  [SLOTS];

  // lowest-numbered free slot
  always_comb begin
    free_o = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_o.found = 1'b1;
        free_o.idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (cmd_i.alloc) begin
      busy_d[free_o.idx] = 1'b1;
    end
    if (cmd_i.release_en) begin
      busy_d[cmd_i.release_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      addr_q[free_o.idx]  <= cmd_i.alloc_addr;
      owner_q[free_o.idx] <= cmd_i.alloc_owner;
      rank_q[free_o.idx]  <= cmd_i.alloc_rank;
    end
    if (cmd_i.rank_dec) begin
      rank_q[cmd_i.rank_idx] <= rank_q[cmd_i.rank_idx] - 1'b1;
    end
  end

  assign rd_o.busy  = busy_q[rd_idx_i];
  assign rd_o.addr  = addr_q[rd_idx_i];
  assign rd_o.owner = owner_q[rd_idx_i];
  assign rd_o.rank  = rank_q[rd_idx_i];

endmodule

`default_nettype wire

[rtl/core/semaphore_wait_queue_core.sv]
// Counting semaphore wait queue: window check, count update and wait list sequencer.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one wait or signal
// transaction on a semaphore whose address, current count and requester id
// travel with it. Output channel (out_valid_o / out_stall_i / out_data_o): one
// result transaction per request with status, count to write back and wake-up.
// The block takes one request at a time; in_stall_o is high while it works.
// A trap, a wait or a signal that leaves the count positive goes straight from
// evaluation to the result; a signal with no matching waiter first scans the
// slot table once; when a waiter is released, one scan picks the oldest
// match and a second renumbers the ranks. The input is free again in the cycle
// the result turns valid. Both scans walk the slot table one entry a cycle,
// the first through a single address/rank comparator.
// The result sits in an output register, so the next request is accepted
// while it waits; a stalled receiver holds the result and the block waits
// only when a second result is ready before the first is taken.
// Reset clears the busy flags, the waiter count and the window registers
// (an empty window traps every address). Configuration writes go through
// cfg_we_i / cfg_idx_i / cfg_wdata_i and are taken at once.

`default_nettype none

module semaphore_wait_queue_core import swq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output resp_t       out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_RENUM = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state_q, state_d;
  req_t              req_q, req_d;
  logic [31:0]       base_q, bytes_q;
  logic [31:0]       res_q, res_d;
  logic [1:0]        status_q, status_d;
  logic [SLOT_W-1:0] scan_q, scan_d;
  logic              pf_q, pf_d;
  logic [SLOT_W-1:0] pidx_q, pidx_d;
  logic [SLOT_W-1:0] prank_q, prank_d;
  logic              wv_q, wv_d;
  logic [7:0]        wid_q, wid_d;
  logic [CNT_W-1:0]  wcnt_q, wcnt_d;
  logic              out_valid_q, out_valid_d;
  resp_t             out_q, out_d;

  slot_cmd_t  cmd;
  slot_rd_t   rd;
  slot_free_t free;

  logic [32:0] win_top;
  logic        in_win;
  logic [31:0] sum;
  logic        hit;

  swq_slot_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .rd_idx_i(scan_q),
    .rd_o    (rd),
    .free_o  (free)
  );

  assign win_top = {1'b0, base_q} + {1'b0, bytes_q};
  assign in_win  = (req_q.sem_addr >= base_q) && ({1'b0, req_q.sem_addr} < win_top);
  assign sum     = req_q.sem_count + ((req_q.req_type == REQ_SIGNAL) ? 32'd1 : 32'hFFFF_FFFF);

  // shared comparator: same address and older than the best pick so far
  assign hit = rd.busy && (rd.addr == req_q.sem_addr) && (!pf_q || (rd.rank < prank_q));

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    status_d    = status_q;
    scan_d      = scan_q;
    pf_d        = pf_q;
    pidx_d      = pidx_q;
    prank_d     = prank_q;
    wv_d        = wv_q;
    wid_d       = wid_q;
    wcnt_d      = wcnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cmd         = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        wv_d     = 1'b0;
        wid_d    = '0;
        res_d    = sum;
        status_d = ST_PROCEED;
        state_d  = S_DONE;
        if (!in_win) begin
          status_d = ST_ADDR_TRAP;
          res_d    = req_q.sem_count;
        end else if (req_q.req_type == REQ_WAIT) begin
          if (sum[31]) begin
            if (free.found) begin
              cmd.alloc       = 1'b1;
              cmd.alloc_addr  = req_q.sem_addr;
              cmd.alloc_owner = req_q.requester;
              cmd.alloc_rank  = wcnt_q[SLOT_W-1:0];
              wcnt_d          = wcnt_q + 1'b1;
              status_d        = ST_BLOCKED;
            end else begin
              status_d = ST_NO_SLOT;
            end
          end
        end else if ((sum == 32'd0) || sum[31]) begin
          scan_d  = '0;
          pf_d    = 1'b0;
          state_d = S_FIND;
        end
      end
      S_FIND: begin
        if (hit) begin
          pf_d    = 1'b1;
          pidx_d  = scan_q;
          prank_d = rd.rank;
          wid_d   = rd.owner;
        end
        if (scan_q == LAST_SLOT) begin
          if (hit || pf_q) begin
            // drop the oldest waiter, then close the gap in the ranks
            cmd.release_en  = 1'b1;
            cmd.release_idx = hit ? scan_q : pidx_q;
            wv_d            = 1'b1;
            if (wcnt_q != '0) begin
              wcnt_d = wcnt_q - 1'b1;
            end
            scan_d  = '0;
            state_d = S_RENUM;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_RENUM: begin
        if (rd.busy && (rd.rank > prank_q)) begin
          cmd.rank_dec = 1'b1;
          cmd.rank_idx = scan_q;
        end
        if (scan_q == LAST_SLOT) begin
          state_d = S_DONE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.status     = status_q;
          out_d.new_count  = res_q;
          out_d.wake_valid = wv_q;
          out_d.wake_id    = wid_q;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wcnt_q      <= '0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
      bytes_q     <= '0;
    end else begin
      state_q     <= state_d;
      wcnt_q      <= wcnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SHARE_BASE:  base_q  <= cfg_wdata_i;
          CFG_SHARE_BYTES: bytes_q <= cfg_wdata_i;
          default:         base_q  <= base_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    res_q    <= res_d;
    status_q <= status_d;
    scan_q   <= scan_d;
    pf_q     <= pf_d;
    pidx_q   <= pidx_d;
    prank_q  <= prank_d;
    wv_q     <= wv_d;
    wid_q    <= wid_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/core/swq_checker.sv]
// Port-level checks of the semaphore wait queue, bound to the top level.
`default_nettype none

module swq_checker import swq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input resp_t       out_data_o
);

  // one request at a time: an accepted transaction stalls the input next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepted transaction");

  // no wake-up id without a wake-up
  a_wake_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.wake_valid) |-> (out_data_o.wake_id == 8'd0))
    else $error("wake id set without wake");

  // a release only comes with a signal that proceeds
  a_wake_proceeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.wake_valid) |-> (out_data_o.status == ST_PROCEED))
    else $error("wake with non-proceed status");

  // a blocked requester always leaves a negative count
  a_block_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ST_BLOCKED)) |-> out_data_o.new_count[31])
    else $error("blocked with non-negative count");

endmodule

bind semaphore_wait_queue_core swq_checker u_swq_checker (.*);

`default_nettype wire
